@@ design/lfu_replacement_cache_defines.svh @@
// Assertion macros for the LFU replacement cache.
// Taken in by the top level; relies on nothing else.
`ifndef LFU_REPLACEMENT_CACHE_DEFINES_SVH
`define LFU_REPLACEMENT_CACHE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LFU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/lfu_pkg.sv @@
// Shared constants for the LFU replacement cache.
// No dependencies; compiled first.
`default_nettype none

package lfu_pkg;

	localparam int KEY_W   = 64;
	localparam int VALUE_W = 32;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

endpackage

`default_nettype wire

@@ design/lfu_req_if.sv @@
// Request channel of the LFU replacement cache: op, key and value with valid/ready.
// Depends on lfu_pkg for the field widths.
`default_nettype none

interface lfu_req_if import lfu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [KEY_W-1:0]   key;
	logic [VALUE_W-1:0] value;

	modport source(output valid, output op, output key, output value, input ready);
	modport sink(input valid, input op, input key, input value, output ready);
endinterface

`default_nettype wire

@@ design/lfu_rsp_if.sv @@
// Response channel of the LFU replacement cache: hit, read value and eviction report.
// Depends on lfu_pkg for the field widths.
`default_nettype none

interface lfu_rsp_if import lfu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               hit;
	logic [VALUE_W-1:0] read_value;
	logic               evicted;
	logic [KEY_W-1:0]   evicted_key;

	modport source(output valid, output hit, output read_value, output evicted,
		output evicted_key, input ready);
	modport sink(input valid, input hit, input read_value, input evicted,
		input evicted_key, output ready);
endinterface

`default_nettype wire

@@ design/lfu_cell.sv @@
// One slot of the LFU cache: holds valid, key, value and use count, folds itself into
// the scan record handed along the row, and applies the commit broadcast. Uses lfu_pkg.
`default_nettype none

module lfu_cell import lfu_pkg::*; #(
	parameter int  SLOTS      = 16,
	parameter int  KEY_BITS   = 64,
	parameter int  COUNT_BITS = 16,
	parameter int  IDX        = 0,
	parameter type scan_t     = logic,
	parameter type cmt_t      = logic
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [KEY_BITS-1:0] req_key,
	input  wire scan_t               link_in,
	output scan_t                    link_out,
	input  wire cmt_t                cmt
);

	localparam int IW = $clog2(SLOTS);
	localparam int OW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] ME = IW'(IDX);

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_W-1:0]    value_q;
	logic [COUNT_BITS-1:0] count_q;

	scan_t nxt;
	scan_t pay_q;
	logic  vld_q;

	// Fold this slot into the running record
	always_comb begin
		nxt = link_in;
		if (valid_q) begin
			nxt.occ = link_in.occ + OW'(1);
			if (key_q == req_key) begin
				nxt.hit       = 1'b1;
				nxt.hit_idx   = ME;
				nxt.hit_value = value_q;
			end
			// strict compare keeps the lowest slot on a tie
			if (!link_in.vic_found || (count_q < link_in.vic_count)) begin
				nxt.vic_found = 1'b1;
				nxt.vic_idx   = ME;
				nxt.vic_count = count_q;
				nxt.vic_key   = key_q;
			end
		end else if (!link_in.free_found) begin
			nxt.free_found = 1'b1;
			nxt.free_idx   = ME;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= link_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (link_in.vld) begin
			pay_q <= nxt;
		end
	end

	always_comb begin
		link_out     = pay_q;
		link_out.vld = vld_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmt.apply) begin
			if (cmt.ins && (cmt.ins_idx == ME)) begin
				valid_q <= 1'b1;
			end else if (cmt.evict && (cmt.vic_idx == ME)) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmt.apply) begin
			if (cmt.ins && (cmt.ins_idx == ME)) begin
				key_q   <= cmt.key;
				value_q <= cmt.value;
				count_q <= COUNT_BITS'(1);
			end else if (cmt.upd && (cmt.hit_idx == ME)) begin
				if (cmt.wr_value) begin
					value_q <= cmt.value;
				end
				// saturate at all ones
				if (count_q != {COUNT_BITS{1'b1}}) begin
					count_q <= count_q + COUNT_BITS'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ design/lfu_replacement_cache.sv @@
// LFU replacement cache, fully associative, SLOTS entries.
// Channels: req (op, key, value) and rsp (hit, read_value, evicted, evicted_key), each a
// valid/ready interface; a beat moves when valid and ready are both high. cfg_we/cfg_wdata
// write the capacity register (0 acts as 1, above SLOTS acts as SLOTS); write it only while
// no request is outstanding.
// Each request beat gives exactly one response beat. After the request beat a scan record
// walks the row of slot cells one cell per cycle; the finished record is held, then the commit
// registers the response. One request is in work at a time: req.ready is high again the
// cycle after the commit, so the next request is not taken before the last one commits.
// The response sits in an output register, so the next request is taken and scanned while
// a response waits; if rsp is still stalled when that scan ends, its commit is held until
// the pending beat leaves.
// Reset (arst_n low) empties every slot, sets capacity to 10 and drops any pending beat.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if, lfu_cell and the assertion macro header.
`default_nettype none

`include "lfu_replacement_cache_defines.svh"

module lfu_replacement_cache import lfu_pkg::*; #(
	parameter int SLOTS      = 16,
	parameter int KEY_BITS   = 64,
	parameter int COUNT_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata,
	lfu_req_if.sink               req,
	lfu_rsp_if.source             rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int OW = $clog2(SLOTS + 1);
	localparam int CW = (OW > CAP_W) ? OW : CAP_W;

	typedef struct packed {
		logic                  vld;
		logic [OW-1:0]         occ;
		logic                  hit;
		logic [IW-1:0]         hit_idx;
		logic [VALUE_W-1:0]    hit_value;
		logic                  vic_found;
		logic [IW-1:0]         vic_idx;
		logic [COUNT_BITS-1:0] vic_count;
		logic [KEY_BITS-1:0]   vic_key;
		logic                  free_found;
		logic [IW-1:0]         free_idx;
	} scan_t;

	typedef struct packed {
		logic                apply;
		logic                upd;
		logic                wr_value;
		logic [IW-1:0]       hit_idx;
		logic                evict;
		logic [IW-1:0]       vic_idx;
		logic                ins;
		logic [IW-1:0]       ins_idx;
		logic [KEY_BITS-1:0] key;
		logic [VALUE_W-1:0]  value;
	} cmt_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t              state_q;
	logic [CAP_W-1:0]    cap_q;
	logic                start_q;
	logic                req_op_q;
	logic [KEY_BITS-1:0] req_key_q;
	logic [VALUE_W-1:0]  req_value_q;
	scan_t               fin_q;

	logic               rsp_vld_q;
	logic               rsp_hit_q;
	logic [VALUE_W-1:0] rsp_rd_q;
	logic               rsp_ev_q;
	logic [KEY_W-1:0]   rsp_evk_q;

	scan_t            link [SLOTS+1];
	logic [SLOTS-1:0] tok_vec;
	cmt_t             cmt;

	logic          accept;
	logic          out_free;
	logic          is_put;
	logic          miss_put;
	logic [CW-1:0] cap_ext;
	logic [CW-1:0] eff_cap;
	logic          full;
	logic          evict;
	logic          use_free;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_vld_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= accept;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (link[SLOTS].vld) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q    <= req.op;
			req_key_q   <= req.key[KEY_BITS-1:0];
			req_value_q <= req.value;
		end
		// hold the finished record until the commit goes out
		if ((state_q == ST_SCAN) && link[SLOTS].vld) begin
			fin_q <= link[SLOTS];
		end
	end

	// Seed of the scan: empty record, launched the cycle after the request beat
	always_comb begin
		link[0]     = '0;
		link[0].vld = start_q;
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		lfu_cell #(
			.SLOTS      (SLOTS),
			.KEY_BITS   (KEY_BITS),
			.COUNT_BITS (COUNT_BITS),
			.IDX        (g),
			.scan_t     (scan_t),
			.cmt_t      (cmt_t)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.req_key  (req_key_q),
			.link_in  (link[g]),
			.link_out (link[g+1]),
			.cmt      (cmt)
		);
		assign tok_vec[g] = link[g+1].vld;
	end

	// Decide the action from the finished record
	always_comb begin
		is_put   = (req_op_q == OP_PUT);
		miss_put = is_put && !fin_q.hit;
		cap_ext  = CW'(cap_q);
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > CW'(SLOTS)) begin
			eff_cap = CW'(SLOTS);
		end else begin
			eff_cap = cap_ext;
		end
		full     = (CW'(fin_q.occ) >= eff_cap);
		evict    = miss_put && full;
		// the victim's slot frees up, so take a lower free slot only if one exists
		use_free = fin_q.free_found && (!evict || (fin_q.free_idx < fin_q.vic_idx));

		cmt          = '0;
		cmt.apply    = (state_q == ST_COMMIT) && out_free;
		cmt.upd      = fin_q.hit;
		cmt.wr_value = is_put;
		cmt.hit_idx  = fin_q.hit_idx;
		cmt.evict    = evict;
		cmt.vic_idx  = fin_q.vic_idx;
		cmt.ins      = miss_put;
		cmt.ins_idx  = use_free ? fin_q.free_idx : fin_q.vic_idx;
		cmt.key      = req_key_q;
		cmt.value    = req_value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (cmt.apply) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmt.apply) begin
			rsp_hit_q <= fin_q.hit;
			rsp_rd_q  <= (!is_put && fin_q.hit) ? fin_q.hit_value : '0;
			rsp_ev_q  <= evict;
			rsp_evk_q <= evict ? KEY_W'(fin_q.vic_key) : '0;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.read_value  = rsp_rd_q;
	assign rsp.evicted     = rsp_ev_q;
	assign rsp.evicted_key = rsp_evk_q;

	`LFU_ASSERT_IMP(a_one_token, clk, arst_n, 1'b1, $countones(tok_vec) <= 1, "two scan records in the cell row")
	`LFU_ASSERT_IMP(a_victim_found, clk, arst_n, cmt.apply && cmt.evict, fin_q.vic_found, "eviction without a victim")
	`LFU_ASSERT_NEXT(a_scan_starts, clk, arst_n, accept, start_q && (state_q == ST_SCAN), "request beat did not launch a scan")
	`LFU_ASSERT_NEXT(a_commit_resp, clk, arst_n, cmt.apply, rsp_vld_q && (state_q == ST_IDLE), "commit did not raise a response")

endmodule

`default_nettype wire

@@ verif/tb_lfu_replacement_cache.sv @@
`timescale 1ns / 100ps
// Self-checking bench for lfu_replacement_cache: directed and random get/put beats, checked
// field by field against a slot-level LFU model held in the bench.
// Needs lfu_pkg, lfu_req_if, lfu_rsp_if and the block itself.

module tb_lfu_replacement_cache;
	import lfu_pkg::*;

	localparam int SLOTS = 16;
	localparam int POOL = 24;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic               op;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} cache_request_t;

	typedef struct packed {
		logic               hit;
		logic [VALUE_W-1:0] read_value;
		logic               evicted;
		logic [KEY_W-1:0]   evicted_key;
	} cache_reply_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	lfu_req_if req_ch ();
	lfu_rsp_if rsp_ch ();

	lfu_replacement_cache uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Bench copy of the slot array and capacity register
	logic               slot_live [SLOTS];
	logic [KEY_W-1:0]   slot_tag  [SLOTS];
	logic [VALUE_W-1:0] slot_data [SLOTS];
	logic [15:0]        slot_uses [SLOTS];
	logic [CAP_W-1:0]   model_capacity;

	cache_request_t   request_backlog [$];
	cache_reply_t     pending_replies [$];
	logic [KEY_W-1:0] key_pool [POOL];

	int          fault_count = 0;
	int unsigned cycle_count = 0;
	logic        throttle = 1'b0;
	int          req_gap = 0;
	int          rsp_stall = 0;

	always #6 clk = ~clk;

	function automatic cache_reply_t lfu_lookup(input cache_request_t r);
		cache_reply_t rep;
		int found, victim, free_slot, occupancy, limit;
		rep = '0;
		found = -1;
		victim = -1;
		free_slot = -1;
		occupancy = 0;
		limit = (model_capacity == 0) ? 1 :
			(model_capacity > SLOTS) ? SLOTS : int'(model_capacity);
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_live[i])
				occupancy++;
			if (found < 0 && slot_live[i] && slot_tag[i] == r.key)
				found = i;
		end
		rep.hit = (found >= 0);
		if (found >= 0) begin
			// hold the count once it saturates
			if (slot_uses[found] != COUNT_MAX)
				slot_uses[found]++;
			if (r.op == OP_GET)
				rep.read_value = slot_data[found];
			else
				slot_data[found] = r.value;
		end else if (r.op == OP_PUT) begin
			if (occupancy >= limit) begin
				// smallest count wins, ties to the lowest slot
				for (int i = 0; i < SLOTS; i++)
					if (slot_live[i] && (victim < 0 || slot_uses[i] < slot_uses[victim]))
						victim = i;
				rep.evicted = 1'b1;
				rep.evicted_key = slot_tag[victim];
				slot_live[victim] = 1'b0;
			end
			for (int i = 0; i < SLOTS; i++)
				if (free_slot < 0 && !slot_live[i])
					free_slot = i;
			slot_live[free_slot] = 1'b1;
			slot_tag[free_slot] = r.key;
			slot_data[free_slot] = r.value;
			slot_uses[free_slot] = 16'd1;
		end
		return rep;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
			fault_count++;
		end
	endtask

	task automatic queue_beat(input logic op, input logic [KEY_W-1:0] key,
		input logic [VALUE_W-1:0] value);
		cache_request_t r;
		r.op = op;
		r.key = key;
		r.value = value;
		request_backlog.insert(request_backlog.size(), r);
	endtask

	task automatic queue_random_beat();
		int pick;
		logic [KEY_W-1:0] k;
		logic [VALUE_W-1:0] v;
		pick = $urandom_range(0, 99);
		// mostly pool keys, a hot few more often, so hits and evictions both occur
		if (pick < 45)
			k = key_pool[$urandom_range(0, 7)];
		else if (pick < 88)
			k = key_pool[$urandom_range(0, POOL-1)];
		else
			k = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			default: v = $urandom;
		endcase
		queue_beat(($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET, k, v);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (request_backlog.size() != 0 || req_ch.valid || pending_replies.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] c);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_capacity = c;
		@(negedge clk);
	endtask

	// Request driver: present the next queued beat, hold it until taken
	always @(posedge clk or negedge arst_n) begin : drive_req
		cache_request_t taken, next_item;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= OP_GET;
			req_ch.key <= '0;
			req_ch.value <= '0;
			req_gap <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				taken.op = req_ch.op;
				taken.key = req_ch.key;
				taken.value = req_ch.value;
				pending_replies.insert(pending_replies.size(), lfu_lookup(taken));
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (req_gap > 0) begin
					req_gap <= req_gap - 1;
					req_ch.valid <= 1'b0;
				end else if (throttle && request_backlog.size() > 0 &&
					$urandom_range(0, 5) == 0) begin
					req_gap <= $urandom_range(0, 4);
					req_ch.valid <= 1'b0;
				end else if (request_backlog.size() > 0) begin
					next_item = request_backlog.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.op <= next_item.op;
					req_ch.key <= next_item.key;
					req_ch.value <= next_item.value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Reply monitor: check each beat against the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin : sink_rsp
		cache_reply_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: unexpected reply beat: expected none actual hit %0b read_value %h evicted %0b evicted_key %h",
						$time, rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted,
						rsp_ch.evicted_key);
					fault_count++;
				end else begin
					want = pending_replies.pop_front();
					check_field("hit", want.hit, rsp_ch.hit);
					check_field("read_value", want.read_value, rsp_ch.read_value);
					check_field("evicted", want.evicted, rsp_ch.evicted);
					check_field("evicted_key", want.evicted_key, rsp_ch.evicted_key);
				end
			end
			if (rsp_stall > 0) begin
				rsp_stall <= rsp_stall - 1;
				rsp_ch.ready <= 1'b0;
			end else if (throttle && $urandom_range(0, 4) == 0) begin
				rsp_stall <= $urandom_range(0, 4);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		logic [CAP_W-1:0] cap_plan [12];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		model_capacity = CAP_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_tag[i] = '0;
			slot_data[i] = '0;
			slot_uses[i] = '0;
		end
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL; i++)
			key_pool[i] = {$urandom, $urandom};
		cap_plan = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd2, 5'd17, 5'd5, 5'd10, 5'd3, 5'd12,
			5'd8, 5'd16};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty miss, insert, hit, update, fill to the reset capacity of ten
		throttle = 1'b1;
		queue_beat(OP_GET, key_pool[0], 32'h0);
		queue_beat(OP_PUT, key_pool[0], '1);
		queue_beat(OP_GET, key_pool[0], 32'h5a5a_5a5a);
		queue_beat(OP_PUT, key_pool[1], '0);
		queue_beat(OP_PUT, key_pool[0], 32'h1234_5678);
		for (int i = 2; i < 10; i++)
			queue_beat(OP_PUT, key_pool[i], $urandom);
		queue_beat(OP_GET, key_pool[2], '0);
		// eleventh key: evict the all-ones key, lowest slot among the count-one ties
		queue_beat(OP_PUT, key_pool[10], 32'hdead_beef);
		queue_beat(OP_GET, key_pool[1], '1);
		queue_beat(OP_PUT, key_pool[1], 32'h0bad_f00d);
		queue_beat(OP_GET, key_pool[10], '0);
		queue_beat(OP_GET, key_pool[0], '0);
		wait_idle();

		// Capacity zero acts as one, and sits below the current occupancy
		set_capacity(cap_plan[0]);
		queue_beat(OP_PUT, key_pool[11], 32'h0000_0001);
		queue_beat(OP_PUT, key_pool[12], 32'h8000_0000);
		queue_beat(OP_GET, key_pool[11], '0);
		queue_beat(OP_GET, key_pool[0], '0);
		repeat (58) queue_random_beat();

		for (int p = 1; p < 12; p++) begin
			wait_idle();
			set_capacity(cap_plan[p]);
			// a stretch with no idling mid-run and at the tail
			throttle = (p != 5 && p != 11);
			repeat (61) queue_random_beat();
		end

		wait_idle();
		repeat (40) @(negedge clk);
		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
